// ===== rtl/sida_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
package sida_pkg;

  // Default width of the signed input value
  localparam int unsigned ValueWidthDef = 32;

  // Magnitude bits consumed by the binary-to-BCD unit in one cycle
  localparam int unsigned BitsPerStep = 4;

  // Character code width and the two character bases
  localparam int unsigned CharWidth = 6;
  localparam logic [CharWidth-1:0] ChZero  = 6'd48;
  localparam logic [CharWidth-1:0] ChMinus = 6'd45;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture a new value and clear the BCD register
    logic step;      // run one shift-and-adjust step
    logic norm;      // find the most significant nonzero digit
    logic dec;       // move to the next lower digit
    logic sel_sign;  // present the minus sign on the output
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic step_last; // current step is the final one
    logic neg;       // value being converted is negative
    logic idx_zero;  // digit pointer is at the least significant digit
  } dp_status_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII text converter.
//
// Input channel (in_valid_i / in_ready_o, payload value_i): one signed
// two's-complement integer per transaction.
// Output channel (out_valid_o / out_ready_i, payload char_code_o, last_char_o):
// the decimal text, most significant character first, one character per
// transaction; a leading '-' for negative values, a lone '0' for zero, and
// last_char_o set on the final character.
// After the input transaction, the value runs through shift-and-add-3
// conversion (4 magnitude bits per cycle), then a step that finds the
// leading digit; the first character then shows. Characters leave
// one per cycle while the receiver is ready.
// One item is in work at a time; in_ready_o is high only when idle.
// When the receiver stalls, the current character holds until taken.
// Reset returns the controller to idle; the datapath registers are not reset.
module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = sida_pkg::ValueWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [VALUE_WIDTH-1:0]         value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sida_pkg::CharWidth-1:0] char_code_o,
  output logic                           last_char_o
);

  sida_pkg::ctrl_cmd_t  cmd;
  sida_pkg::dp_status_t status;

  sida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sida_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule

// ===== rtl/sida_dp.sv =====
// Datapath: magnitude, iterative binary-to-BCD conversion and digit output select.
module sida_dp #(
  parameter int unsigned VALUE_WIDTH = sida_pkg::ValueWidthDef
) (
  input  logic                             clk_i,
  input  logic [VALUE_WIDTH-1:0]           value_i,
  input  sida_pkg::ctrl_cmd_t              cmd_i,
  output sida_pkg::dp_status_t             status_o,
  output logic [sida_pkg::CharWidth-1:0]   char_code_o,
  output logic                             last_char_o
);

  localparam int unsigned Bps    = sida_pkg::BitsPerStep;
  localparam int unsigned MagW   = ((VALUE_WIDTH + Bps - 1) / Bps) * Bps;
  localparam int unsigned Steps  = MagW / Bps;
  localparam int unsigned NumDig = ((MagW * 1233) >> 12) + 1;
  localparam int unsigned IdxW   = (NumDig > 1) ? $clog2(NumDig) : 1;
  localparam int unsigned CntW   = (Steps > 1) ? $clog2(Steps) : 1;

  logic [MagW-1:0]             mag_q, mag_d, mag_step;
  logic [NumDig-1:0][3:0]      bcd_q, bcd_d, bcd_step;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [IdxW-1:0]             idx_q, idx_d, idx_top;
  logic                        neg_q, neg_d;
  logic                        in_neg;
  logic [VALUE_WIDTH-1:0]      in_mag;
  logic [3:0]                  cur_digit;

  // Take the magnitude; the most negative value wraps to its correct unsigned form
  assign in_neg = value_i[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~value_i + VALUE_WIDTH'(1)) : value_i;

  // Shift-and-add-3 over several magnitude bits, most significant bit first
  always_comb begin
    bcd_step = bcd_q;
    mag_step = mag_q;
    for (int b = 0; b < Bps; b++) begin
      for (int d = 0; d < NumDig; d++) begin
        if (bcd_step[d] >= 4'd5) begin
          bcd_step[d] = bcd_step[d] + 4'd3;
        end
      end
      {bcd_step, mag_step} = {bcd_step, mag_step} << 1;
    end
  end

  // Locate the most significant nonzero digit, zero if all digits are zero
  always_comb begin
    idx_top = '0;
    for (int d = 0; d < NumDig; d++) begin
      if (bcd_q[d] != 4'd0) begin
        idx_top = IdxW'(d);
      end
    end
  end

  // Next-state of the datapath registers
  always_comb begin
    mag_d = mag_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    neg_d = neg_q;
    if (cmd_i.load) begin
      mag_d = MagW'(in_mag);
      bcd_d = '0;
      cnt_d = CntW'(Steps - 1);
      neg_d = in_neg;
    end else if (cmd_i.step) begin
      mag_d = mag_step;
      bcd_d = bcd_step;
      cnt_d = cnt_q - CntW'(1);
    end else if (cmd_i.norm) begin
      idx_d = idx_top;
    end else if (cmd_i.dec) begin
      idx_d = idx_q - IdxW'(1);
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    cnt_q <= cnt_d;
    idx_q <= idx_d;
    neg_q <= neg_d;
  end

  // Status back to the controller
  assign status_o.step_last = (cnt_q == '0);
  assign status_o.neg       = neg_q;
  assign status_o.idx_zero  = (idx_q == '0);

  // Select the outgoing character
  assign cur_digit   = bcd_q[idx_q];
  assign char_code_o = cmd_i.sel_sign ? sida_pkg::ChMinus
                                      : (sida_pkg::ChZero + {2'b00, cur_digit});
  assign last_char_o = !cmd_i.sel_sign && (idx_q == '0);

endmodule

// ===== rtl/sida_ctrl.sv =====
// Controller: sequences load, conversion, normalization and character output.
module sida_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  sida_pkg::dp_status_t   status_i,
  output sida_pkg::ctrl_cmd_t    cmd_o
);

  sida_pkg::state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sida_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sida_pkg::ST_CONV;
      end
      sida_pkg::ST_CONV: begin
        if (status_i.step_last) state_d = sida_pkg::ST_NORM;
      end
      sida_pkg::ST_NORM: begin
        state_d = status_i.neg ? sida_pkg::ST_SIGN : sida_pkg::ST_DIGIT;
      end
      sida_pkg::ST_SIGN: begin
        if (out_ready_i) state_d = sida_pkg::ST_DIGIT;
      end
      sida_pkg::ST_DIGIT: begin
        if (out_ready_i && status_i.idx_zero) state_d = sida_pkg::ST_IDLE;
      end
      default: state_d = sida_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      sida_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sida_pkg::ST_CONV: begin
        cmd_o.step = 1'b1;
      end
      sida_pkg::ST_NORM: begin
        cmd_o.norm = 1'b1;
      end
      sida_pkg::ST_SIGN: begin
        out_valid_o    = 1'b1;
        cmd_o.sel_sign = 1'b1;
      end
      sida_pkg::ST_DIGIT: begin
        out_valid_o = 1'b1;
        cmd_o.dec   = out_ready_i && !status_i.idx_zero;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sida_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/sida_chk.sv =====
// Port-level assertions for the converter, bound to the top level.
module sida_chk #(
  parameter int unsigned VALUE_WIDTH = sida_pkg::ValueWidthDef
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [VALUE_WIDTH-1:0]         value_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [sida_pkg::CharWidth-1:0] char_code_o,
  input logic                           last_char_o
);

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_code_o)
      && $stable(last_char_o))
    else $error("stalled output character changed");

  // Never take a new item while characters are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while output valid");

  // After a value is accepted, the block is neither ready nor valid in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("block not busy after accepting a value");

  // Only a minus sign or a decimal digit appears
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == sida_pkg::ChMinus)
      || ((char_code_o >= sida_pkg::ChZero) && (char_code_o <= 6'd57)))
    else $error("illegal character code");

  // A minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (char_code_o == sida_pkg::ChMinus) |-> !last_char_o)
    else $error("minus sign flagged as last character");

endmodule

bind signed_int_to_decimal_ascii sida_chk #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_sida_chk (.*);

// ===== dv/signed_int_to_decimal_ascii_tb.sv =====
// Testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;

  localparam int unsigned VW = sida_pkg::ValueWidthDef;
  localparam int LONG_HOLD = 160;
  localparam int TAIL_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 98;
  localparam int NUM_DIRECTED = 22;

  // One character of decimal text as it leaves the block
  typedef struct packed {
    logic [sida_pkg::CharWidth-1:0] code;
    logic                           last;
  } text_char_t;

  // Directed row: empty text means the predictor supplies the expectation
  typedef struct {
    logic [VW-1:0] value;
    string         text;
  } number_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [VW-1:0]                  value_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [sida_pkg::CharWidth-1:0] char_code_o;
  logic                           last_char_o;

  text_char_t pending_chars[$];
  text_char_t want_char;
  int         mismatches = 0;
  int         numbers_sent = 0;
  int         negatives_sent = 0;
  int         chars_checked = 0;
  int         burst_left = 0;
  bit         steady_sender = 1'b0;
  int         holds_asked = 0;
  int         holds_served = 0;
  int         hold_left = 0;
  int         rx_cycle = 0;
  int         quiet_cycles = 0;

  number_row_t number_rows [NUM_DIRECTED] = '{
    '{32'd0,           "0"},
    '{32'd1,           "1"},
    '{32'hFFFF_FFFF,   "-1"},
    '{32'd9,           "9"},
    '{32'd10,          "10"},
    '{-32'sd10,        "-10"},
    '{32'd99,          "99"},
    '{32'd100,         "100"},
    '{-32'sd100,       "-100"},
    '{32'd65535,       "65535"},
    '{-32'sd32768,     "-32768"},
    '{32'd1000000000,  "1000000000"},
    '{-32'sd999999999, "-999999999"},
    '{32'd1234567890,  "1234567890"},
    '{32'h7FFF_FFFF,   "2147483647"},
    '{32'h8000_0001,   "-2147483647"},
    '{32'h8000_0000,   "-2147483648"},
    '{32'h5555_5555,   ""},
    '{32'hAAAA_AAAA,   ""},
    '{32'hC000_0000,   ""},
    '{32'h0000_FFFF,   ""},
    '{32'hFFFF_0000,   ""}
  };

  signed_int_to_decimal_ascii #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  // Generate the 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Queue the decimal text of a value: optional minus, then digits MSD first
  function automatic void push_decimal_text(input logic [VW-1:0] v);
    logic [VW-1:0] mag;
    bit            is_neg;
    byte unsigned  digs[$];
    text_char_t    ch;
    is_neg = v[VW-1];
    // Unsigned negation covers the most negative value
    mag = is_neg ? (~v + 1'b1) : v;
    do begin
      digs.push_front(byte'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (is_neg) begin
      ch.code = sida_pkg::ChMinus;
      ch.last = 1'b0;
      pending_chars.push_back(ch);
    end
    foreach (digs[i]) begin
      ch.code = sida_pkg::ChZero + sida_pkg::CharWidth'(digs[i]);
      ch.last = (i == digs.size() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  // Queue typed-in text, flagging its final character
  function automatic void push_typed_text(input string text);
    byte        c;
    text_char_t ch;
    for (int i = 0; i < text.len(); i++) begin
      c = text[i];
      ch.code = c[sida_pkg::CharWidth-1:0];
      ch.last = (i == text.len() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  // Pick a value that lands on every text length, both signs and the extremes
  function automatic logic [VW-1:0] pick_value();
    longint lo;
    longint hi;
    longint mag;
    int     ndig;
    bit     neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: mag = $urandom_range(0, 20);
      2: begin
        ndig = $urandom_range(1, 10);
        lo = 1;
        for (int i = 1; i < ndig; i++) lo = lo * 10;
        hi = (ndig == 10) ? 64'd2147483647 : lo * 10 - 1;
        mag = lo + $urandom_range(0, int'(hi - lo));
      end
      3: begin
        if (neg) return 32'h8000_0000 + $urandom_range(0, 3);
        return 32'h7FFF_FFFF - $urandom_range(0, 3);
      end
      default: begin
        ndig = $urandom_range(1, 9);
        mag = 1;
        for (int i = 0; i < ndig; i++) mag = mag * 10;
        mag = mag + $urandom_range(0, 2) - 1;
      end
    endcase
    return neg ? VW'(-mag) : VW'(mag);
  endfunction

  // Offer one value and hold it until the block takes it
  task automatic offer_value(input logic [VW-1:0] v, input string text);
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    if (text.len() == 0) push_decimal_text(v);
    else push_typed_text(text);
    numbers_sent++;
    if (v[VW-1]) negatives_sent++;
  endtask

  // End a burst now and then with a random gap
  task automatic sender_gap();
    int gap;
    if (steady_sender) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 7);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every queued character to come out
  task automatic drain_pause();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: long hold-offs on request, else a rotating stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      rx_cycle     <= 0;
      hold_left    <= 0;
      holds_served <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served <= holds_served + 1;
        hold_left    <= LONG_HOLD;
        out_ready_i  <= 1'b0;
      end else begin
        case (rx_cycle[8:7])
          2'd0: out_ready_i <= 1'b1;
          2'd1: out_ready_i <= 1'($urandom_range(0, 1));
          2'd2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  // Compare each character transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: char_code %0d, last_char %0b", char_code_o, last_char_o);
        mismatches++;
      end else begin
        want_char = pending_chars.pop_front();
        chars_checked++;
        if (char_code_o !== want_char.code) begin
          $error("char_code: expected %0d, actual %0d", want_char.code, char_code_o);
          mismatches++;
        end
        if (last_char_o !== want_char.last) begin
          $error("last_char: expected %0b, actual %0b", want_char.last, last_char_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed table, random numbers with pressure phases
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (number_rows[i]) begin
      offer_value(number_rows[i].value, number_rows[i].text);
      sender_gap();
    end
    drain_pause();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Hold off the receiver and keep offering so the input stalls
      if (n == 30) begin
        holds_asked <= holds_asked + 1;
        steady_sender = 1'b1;
      end
      if (n == 40) steady_sender = 1'b0;
      // Back-to-back stretch with no sender gaps
      if (n == 80) steady_sender = 1'b1;
      if (n == 92) steady_sender = 1'b0;
      offer_value(pick_value(), "");
      if (n == 65) drain_pause();
      else sender_gap();
    end

    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      $error("char_code: %0d expected characters never arrived", pending_chars.size());
      mismatches++;
    end

    $display("Converted %0d integers (%0d negative) into %0d checked characters,",
             numbers_sent, negatives_sent, chars_checked);
    $display("with sender bursts, receiver stalls and a long output hold-off.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
